@@ hw/rtl/cwfq_pkg.sv @@
`timescale 1ns / 1ps
package cwfq_pkg;
    localparam int unsigned WEIGHT_W = 16;
    localparam int unsigned IDENT_W  = 32;
    localparam int unsigned SIZE_W   = 16;
    localparam int unsigned TIME_W   = 64;
    localparam int unsigned CLASS_W  = 2;
    localparam int unsigned STATUS_W = 2;
    localparam int unsigned CFG_IDX_W = 2;

    typedef enum logic [STATUS_W-1:0] {
        ST_ENQUEUED = 2'd0,
        ST_DEQUEUED = 2'd1,
        ST_EMPTY    = 2'd2,
        ST_FULL     = 2'd3
    } t_status;

    typedef enum logic {
        KIND_ENQ = 1'b0,
        KIND_DEQ = 1'b1
    } t_kind;

    typedef enum logic [3:0] {
        S_IDLE, S_ENQ_CHECK, S_DIV_START, S_DIV_RUN, S_ENQ_WRITE,
        S_DEQ_READ, S_DEQ_WAIT, S_DEQ_SCAN, S_DEQ_FETCH, S_DEQ_FETCH_WAIT,
        S_DEQ_POP, S_OUT
    } t_state;

    typedef struct packed {
        logic load_item;
        logic enq_check;
        logic div_start;
        logic div_step;
        logic enq_write;
        logic scan_rd;
        logic scan_cmp;
        logic scan_next;
        logic fetch_rd;
        logic deq_pop;
        logic set_empty;
        logic set_full;
    } t_cmd;

    typedef struct packed {
        logic kind_deq;
        logic enq_reject;
        logic div_done;
        logic scan_last;
        logic found;
    } t_sts;
endpackage

@@ hw/rtl/cwfq_if.sv @@
`timescale 1ns / 1ps
interface cwfq_in_if;
    logic        valid;
    logic        ready;
    logic        kind;
    logic [31:0] packet_ident;
    logic [1:0]  traffic_class;
    logic [15:0] size_in_bytes;
    modport source (output valid, kind, packet_ident, traffic_class, size_in_bytes,
                    input ready);
    modport sink   (input valid, kind, packet_ident, traffic_class, size_in_bytes,
                    output ready);
endinterface

interface cwfq_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [31:0] out_packet_ident;
    logic [63:0] out_finish_time;
    modport source (output valid, status, out_packet_ident, out_finish_time, input ready);
    modport sink   (input valid, status, out_packet_ident, out_finish_time, output ready);
endinterface

interface cwfq_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [15:0] data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

@@ hw/rtl/cwfq_ctrl.sv @@
`timescale 1ns / 1ps
module cwfq_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    output logic            o_out_valid,
    input  logic            i_out_ready,
    input  cwfq_pkg::t_sts  i_sts,
    output cwfq_pkg::t_cmd  o_cmd
);
    import cwfq_pkg::*;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) n_state = S_ENQ_CHECK;
            end
            S_ENQ_CHECK: begin
                if (i_sts.kind_deq) n_state = S_DEQ_READ;
                else if (i_sts.enq_reject) n_state = S_OUT;
                else n_state = S_DIV_START;
            end
            S_DIV_START: n_state = S_DIV_RUN;
            S_DIV_RUN: begin
                if (i_sts.div_done) n_state = S_ENQ_WRITE;
            end
            S_ENQ_WRITE: n_state = S_OUT;
            S_DEQ_READ:  n_state = S_DEQ_WAIT;
            S_DEQ_WAIT:  n_state = S_DEQ_SCAN;
            S_DEQ_SCAN: begin
                if (!i_sts.scan_last) n_state = S_DEQ_READ;
                else n_state = S_DEQ_FETCH;
            end
            S_DEQ_FETCH: begin
                if (i_sts.found) n_state = S_DEQ_FETCH_WAIT;
                else n_state = S_OUT;
            end
            S_DEQ_FETCH_WAIT: n_state = S_DEQ_POP;
            S_DEQ_POP: n_state = S_OUT;
            S_OUT: begin
                if (i_out_ready) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd       = '0;
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load_item = i_in_valid;
            end
            S_ENQ_CHECK: begin
                o_cmd.enq_check = 1'b1;
                o_cmd.set_full  = !i_sts.kind_deq && i_sts.enq_reject;
            end
            S_DIV_START: o_cmd.div_start = 1'b1;
            S_DIV_RUN:   o_cmd.div_step  = 1'b1;
            S_ENQ_WRITE: o_cmd.enq_write = 1'b1;
            S_DEQ_READ:  o_cmd.scan_rd   = 1'b1;
            S_DEQ_WAIT:  ;
            S_DEQ_SCAN: begin
                o_cmd.scan_cmp  = 1'b1;
                o_cmd.scan_next = 1'b1;
            end
            S_DEQ_FETCH: begin
                o_cmd.fetch_rd  = i_sts.found;
                o_cmd.set_empty = !i_sts.found;
            end
            S_DEQ_FETCH_WAIT: ;
            S_DEQ_POP:   o_cmd.deq_pop = 1'b1;
            S_OUT:       o_out_valid = 1'b1;
            default: ;
        endcase
    end

    a_ready_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_ready |-> !o_out_valid) else $error("ready while result pending");
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> o_out_valid) else $error("result dropped");
    a_div_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV_RUN && i_sts.div_done) |=> r_state == S_ENQ_WRITE)
        else $error("divide did not finish cleanly");
endmodule

@@ hw/rtl/cwfq_datapath.sv @@
`timescale 1ns / 1ps
module cwfq_datapath #(
    parameter int unsigned NUM_CLASSES = 4,
    parameter int unsigned QUEUE_DEPTH = 16,
    parameter int unsigned FRAC_BITS   = 16
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  cwfq_pkg::t_cmd              i_cmd,
    output cwfq_pkg::t_sts              o_sts,
    input  logic                        i_kind,
    input  logic [31:0]                 i_ident,
    input  logic [1:0]                  i_class,
    input  logic [15:0]                 i_size,
    input  logic                        i_cfg_we,
    input  logic [1:0]                  i_cfg_idx,
    input  logic [15:0]                 i_cfg_data,
    output logic [1:0]                  o_status,
    output logic [31:0]                 o_ident,
    output logic [63:0]                 o_finish
);
    import cwfq_pkg::*;

    localparam int unsigned CW = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;
    localparam int unsigned QW = $clog2(QUEUE_DEPTH);
    localparam int unsigned AW = CW + QW;
    localparam int unsigned NW = QW + 1;
    localparam int unsigned DEPTH_ALL = NUM_CLASSES * (2 ** QW);
    localparam int unsigned DIVW = SIZE_W + 3 + FRAC_BITS;
    localparam int unsigned DCW = $clog2(DIVW + 1);

    logic [IDENT_W-1:0] mem_id [DEPTH_ALL];
    logic [TIME_W-1:0]  mem_fin [DEPTH_ALL];

    logic [WEIGHT_W-1:0] r_weight [NUM_CLASSES];
    logic [QW-1:0]       r_head [NUM_CLASSES];
    logic [NW-1:0]       r_count [NUM_CLASSES];
    logic [TIME_W-1:0]   r_last [NUM_CLASSES];
    logic [TIME_W-1:0]   r_vclock;

    logic                r_kind;
    logic [IDENT_W-1:0]  r_ident;
    logic [CLASS_W-1:0]  r_class;
    logic [SIZE_W-1:0]   r_size;
    logic [TIME_W-1:0]   r_start;
    logic [WEIGHT_W-1:0] r_div_w;
    logic [DIVW-1:0]     r_quo;
    logic [WEIGHT_W:0]   r_rem;
    logic [DCW-1:0]      r_div_cnt;
    logic [CW-1:0]       r_scan;
    logic                r_found;
    logic [CW-1:0]       r_best;
    logic [TIME_W-1:0]   r_best_fin;
    logic [IDENT_W-1:0]  r_rd_id;
    logic [TIME_W-1:0]   r_rd_fin;
    logic [1:0]          r_status;
    logic [IDENT_W-1:0]  r_out_id;
    logic [TIME_W-1:0]   r_out_fin;

    logic [CW-1:0]  cls;
    logic           cls_ok;
    logic [AW-1:0]  rd_addr;
    logic [AW-1:0]  wr_addr;
    logic [NW-1:0]  tail_sum;
    logic [QW-1:0]  tail;
    logic [TIME_W:0] sum;
    logic [WEIGHT_W:0] rem_sh;
    logic [WEIGHT_W:0] rem_sub;
    logic           rd_en;
    logic [DIVW-1:0] dividend;

    assign cls    = CW'(r_class);
    assign cls_ok = ({{(32-CLASS_W){1'b0}}, r_class} < NUM_CLASSES);
    // tail slot wraps at the queue depth
    assign tail_sum = NW'(r_head[cls]) + r_count[cls];
    assign tail   = (tail_sum >= NW'(QUEUE_DEPTH)) ? QW'(tail_sum - NW'(QUEUE_DEPTH))
                                                   : QW'(tail_sum);
    assign wr_addr = {cls, tail};
    assign rd_en  = i_cmd.scan_rd || i_cmd.fetch_rd;
    assign rd_addr = i_cmd.fetch_rd ? {r_best, r_head[r_best]} : {r_scan, r_head[r_scan]};
    assign dividend = {((r_size == '0) ? SIZE_W'(1) : r_size), 3'b000, {FRAC_BITS{1'b0}}};
    assign rem_sh  = {r_rem[WEIGHT_W-1:0], r_quo[DIVW-1]};
    assign rem_sub = rem_sh - {1'b0, r_div_w};
    assign sum     = {1'b0, r_start} + {{(TIME_W+1-DIVW){1'b0}}, r_quo};

    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_rd_id  <= mem_id[rd_addr];
            r_rd_fin <= mem_fin[rd_addr];
        end
        if (i_cmd.enq_write) begin
            mem_id[wr_addr]  <= r_ident;
            mem_fin[wr_addr] <= sum[TIME_W] ? '1 : sum[TIME_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_item) begin
            r_kind  <= i_kind;
            r_ident <= i_ident;
            r_class <= i_class;
            r_size  <= i_size;
        end
        if (i_cmd.enq_check) begin
            r_start  <= (r_vclock > r_last[cls]) ? r_vclock : r_last[cls];
            r_div_w  <= (r_weight[cls] == '0) ? WEIGHT_W'(1) : r_weight[cls];
        end
        if (i_cmd.div_start) begin
            r_quo     <= dividend;
            r_rem     <= '0;
            r_div_cnt <= DCW'(DIVW);
        end else if (i_cmd.div_step && r_div_cnt != '0) begin
            r_div_cnt <= r_div_cnt - 1'b1;
            if (!rem_sub[WEIGHT_W]) begin
                r_rem <= rem_sub;
                r_quo <= {r_quo[DIVW-2:0], 1'b1};
            end else begin
                r_rem <= rem_sh;
                r_quo <= {r_quo[DIVW-2:0], 1'b0};
            end
        end
        if (i_cmd.scan_cmp) begin
            if (r_count[r_scan] != '0 && (!r_found || r_rd_fin < r_best_fin)) begin
                r_best     <= r_scan;
                r_best_fin <= r_rd_fin;
            end
        end
        if (i_cmd.enq_write) begin
            r_status  <= ST_ENQUEUED;
            r_out_id  <= '0;
            r_out_fin <= sum[TIME_W] ? '1 : sum[TIME_W-1:0];
        end
        if (i_cmd.set_full || i_cmd.set_empty) begin
            r_status  <= i_cmd.set_full ? ST_FULL : ST_EMPTY;
            r_out_id  <= '0;
            r_out_fin <= '0;
        end
        if (i_cmd.deq_pop) begin
            r_status  <= ST_DEQUEUED;
            r_out_id  <= r_rd_id;
            r_out_fin <= r_rd_fin;
        end
    end

    // control state: queue pointers, clocks, weights, scan bookkeeping
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int c = 0; c < NUM_CLASSES; c++) begin
                r_weight[c] <= WEIGHT_W'(1);
                r_head[c]   <= '0;
                r_count[c]  <= '0;
                r_last[c]   <= '0;
            end
            r_vclock <= '0;
            r_scan   <= '0;
            r_found  <= 1'b0;
        end else begin
            if (i_cfg_we && ({{(32-CFG_IDX_W){1'b0}}, i_cfg_idx} < NUM_CLASSES)) begin
                r_weight[CW'(i_cfg_idx)] <= i_cfg_data;
            end
            if (i_cmd.load_item) begin
                r_scan  <= '0;
                r_found <= 1'b0;
            end
            if (i_cmd.scan_next) begin
                r_scan <= CW'(r_scan + 1'b1);
                if (r_count[r_scan] != '0) r_found <= 1'b1;
            end
            if (i_cmd.enq_write) begin
                r_last[cls]  <= sum[TIME_W] ? '1 : sum[TIME_W-1:0];
                r_count[cls] <= r_count[cls] + 1'b1;
            end
            if (i_cmd.deq_pop) begin
                r_head[r_best]  <= (r_head[r_best] == QW'(QUEUE_DEPTH - 1)) ? '0
                                   : QW'(r_head[r_best] + 1'b1);
                r_count[r_best] <= r_count[r_best] - 1'b1;
                if (r_rd_fin > r_vclock) r_vclock <= r_rd_fin;
            end
        end
    end

    assign o_sts.kind_deq   = (r_kind == KIND_DEQ);
    assign o_sts.enq_reject = !cls_ok || (r_count[cls] >= NW'(QUEUE_DEPTH));
    assign o_sts.div_done   = (r_div_cnt == '0);
    assign o_sts.scan_last  = ({{(32-CW){1'b0}}, r_scan} == NUM_CLASSES - 1);
    assign o_sts.found      = r_found;
    assign o_status = r_status;
    assign o_ident  = r_out_id;
    assign o_finish = r_out_fin;

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.enq_write |-> r_count[cls] < NW'(QUEUE_DEPTH)) else $error("write to full queue");
    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.deq_pop |-> r_count[r_best] != '0) else $error("pop from empty queue");
    a_vclock_mono: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> r_vclock >= $past(r_vclock)) else $error("virtual clock fell");
endmodule

@@ hw/rtl/class_weighted_fair_queue_scheduler_core.sv @@
`timescale 1ns / 1ps
// Class-based weighted fair queueing scheduler. An enqueue item stamps the packet with a
// finish time (start = max(class last finish, virtual clock), plus 8*size<<16 / weight,
// saturating) and stores it in its class FIFO; a dequeue item pops the head with the
// smallest finish time, lowest class on ties. One item at a time: an enqueue's run is set
// by the restoring divider retiring one quotient bit per cycle (35 bits); a dequeue's run
// is set by the single-port head scan, which steps each class through S_DEQ_READ, S_DEQ_WAIT
// and S_DEQ_SCAN. Full queue or bad class returns status 3; an empty dequeue returns status 2.
module class_weighted_fair_queue_scheduler_core #(
    parameter int unsigned NUM_CLASSES = 4,
    parameter int unsigned QUEUE_DEPTH = 16,
    parameter int unsigned FRAC_BITS   = 16
) (
    input logic i_clk,
    input logic i_rst_n,
    cwfq_in_if.sink    in_ch,
    cwfq_out_if.source out_ch,
    cwfq_cfg_if.sink   cfg_ch
);
    import cwfq_pkg::*;

    t_cmd cmd;
    t_sts sts;

    // config always accepted; writes land only while idle by contract
    assign cfg_ch.ready = 1'b1;

    cwfq_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (in_ch.valid),
        .o_in_ready (in_ch.ready),
        .o_out_valid(out_ch.valid),
        .i_out_ready(out_ch.ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    cwfq_datapath #(
        .NUM_CLASSES(NUM_CLASSES),
        .QUEUE_DEPTH(QUEUE_DEPTH),
        .FRAC_BITS  (FRAC_BITS)
    ) u_dp (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd     (cmd),
        .o_sts     (sts),
        .i_kind    (in_ch.kind),
        .i_ident   (in_ch.packet_ident),
        .i_class   (in_ch.traffic_class),
        .i_size    (in_ch.size_in_bytes),
        .i_cfg_we  (cfg_ch.valid),
        .i_cfg_idx (cfg_ch.index),
        .i_cfg_data(cfg_ch.data),
        .o_status  (out_ch.status),
        .o_ident   (out_ch.out_packet_ident),
        .o_finish  (out_ch.out_finish_time)
    );
endmodule

@@ verif/tb_top.sv @@
`timescale 1ns / 1ps
module tb_top;
    import cwfq_pkg::*;

    typedef struct packed {
        logic        kind;
        logic [31:0] ident;
        logic [1:0]  cls;
        logic [15:0] size;
    } t_pkt_item;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] ident;
        logic [63:0] finish;
    } t_sched_result;

    localparam int unsigned NCLS  = 4;
    localparam int unsigned DEPTH = 16;
    localparam longint unsigned CYCLE_LIMIT = 2_000_000;

    logic i_clk;
    logic i_rst_n;

    cwfq_in_if  in_ch ();
    cwfq_out_if out_ch ();
    cwfq_cfg_if cfg_ch ();

    class_weighted_fair_queue_scheduler_core uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .in_ch   (in_ch),
        .out_ch  (out_ch),
        .cfg_ch  (cfg_ch)
    );

    // scheduler shadow state
    logic [31:0] sh_ids    [NCLS][DEPTH];
    logic [63:0] sh_finish [NCLS][DEPTH];
    int unsigned sh_head [NCLS];
    int unsigned sh_count[NCLS];
    logic [63:0] sh_last [NCLS];
    logic [63:0] sh_vclock;
    logic [15:0] sh_weight[NCLS];

    t_pkt_item     pending_items[$];
    t_sched_result expected_results[$];

    int  mismatches;
    longint unsigned cycle_count;
    int  sink_hold;
    int  src_gap;
    bit  long_hold_req;
    bit  driving_done;

    function automatic t_sched_result schedule_item(t_pkt_item it);
        t_sched_result r;
        logic [63:0] start, cost, fin, bytes, w, best_f;
        int best;
        bit found;
        r = '0;
        if (it.kind == KIND_ENQ) begin
            if (sh_count[it.cls] >= DEPTH) begin
                r.status = ST_FULL;
                return r;
            end
            start = sh_last[it.cls];
            if (sh_vclock > start) start = sh_vclock;
            bytes = (it.size == 0) ? 64'd1 : 64'(it.size);
            w = (sh_weight[it.cls] == 0) ? 64'd1 : 64'(sh_weight[it.cls]);
            cost = ((bytes * 8) << 16) / w;
            fin = start + cost;
            if (fin < start) fin = '1;
            sh_last[it.cls] = fin;
            sh_ids[it.cls][(sh_head[it.cls] + sh_count[it.cls]) % DEPTH] = it.ident;
            sh_finish[it.cls][(sh_head[it.cls] + sh_count[it.cls]) % DEPTH] = fin;
            sh_count[it.cls]++;
            r.status = ST_ENQUEUED;
            r.finish = fin;
        end else begin
            found = 0;
            best = 0;
            best_f = 0;
            for (int c = 0; c < NCLS; c++) begin
                if (sh_count[c] != 0 && (!found || sh_finish[c][sh_head[c]] < best_f)) begin
                    found = 1;
                    best = c;
                    best_f = sh_finish[c][sh_head[c]];
                end
            end
            if (!found) begin
                r.status = ST_EMPTY;
                return r;
            end
            r.status = ST_DEQUEUED;
            r.ident = sh_ids[best][sh_head[best]];
            r.finish = best_f;
            sh_head[best] = (sh_head[best] + 1) % DEPTH;
            sh_count[best]--;
            if (best_f > sh_vclock) sh_vclock = best_f;
        end
        return r;
    endfunction

    function automatic int pick_gap();
        if ($urandom_range(0, 19) == 0) return $urandom_range(20, 80);
        if ($urandom_range(0, 2) == 0) return 0;
        return $urandom_range(0, 3);
    endfunction

    initial begin
        i_clk = 0;
        forever #2 i_clk = ~i_clk;
    end

    // input driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
            src_gap <= 0;
        end else begin
            if (in_ch.valid && in_ch.ready) begin
                expected_results.push_back(schedule_item(pending_items.pop_front()));
            end
            if (in_ch.valid && !in_ch.ready) begin
                // hold offer
            end else if (src_gap > 0) begin
                in_ch.valid <= 1'b0;
                src_gap <= src_gap - 1;
            end else if (pending_items.size() > 0 && !driving_done) begin
                in_ch.valid         <= 1'b1;
                in_ch.kind          <= pending_items[0].kind;
                in_ch.packet_ident  <= pending_items[0].ident;
                in_ch.traffic_class <= pending_items[0].cls;
                in_ch.size_in_bytes <= pending_items[0].size;
                src_gap <= pick_gap();
            end else begin
                in_ch.valid <= 1'b0;
            end
        end
    end

    // result monitor
    always @(posedge i_clk) begin
        t_sched_result exp_r;
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
            sink_hold <= 0;
        end else begin
            if (out_ch.valid && out_ch.ready) begin
                if (expected_results.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result status=%0d id=%h fin=%h",
                                 out_ch.status, out_ch.out_packet_ident,
                                 out_ch.out_finish_time);
                end else begin
                    exp_r = expected_results.pop_front();
                    if (out_ch.status !== exp_r.status
                        || out_ch.out_packet_ident !== exp_r.ident
                        || out_ch.out_finish_time !== exp_r.finish) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch exp st=%0d id=%h fin=%h got st=%0d id=%h fin=%h",
                                     exp_r.status, exp_r.ident, exp_r.finish,
                                     out_ch.status, out_ch.out_packet_ident,
                                     out_ch.out_finish_time);
                    end
                end
            end
            if (long_hold_req) begin
                out_ch.ready <= 1'b0;
                sink_hold <= 1500;
            end else if (sink_hold > 0) begin
                out_ch.ready <= 1'b0;
                sink_hold <= sink_hold - 1;
            end else begin
                out_ch.ready <= 1'b1;
                if ($urandom_range(0, 3) == 0) sink_hold <= pick_gap();
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("tb_top: errors");
            $finish;
        end
    end

    task automatic write_weight(input logic [1:0] idx, input logic [15:0] val);
        cfg_ch.index <= idx;
        cfg_ch.data  <= val;
        cfg_ch.valid <= 1'b1;
        do @(posedge i_clk); while (!cfg_ch.ready);
        sh_weight[idx] = val;
        cfg_ch.valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic wait_drained();
        while (pending_items.size() > 0 || in_ch.valid || expected_results.size() > 0)
            @(posedge i_clk);
        repeat (100) @(posedge i_clk);
    endtask

    function automatic t_pkt_item rand_enq(int unsigned cls);
        t_pkt_item it;
        it.kind = KIND_ENQ;
        it.ident = $urandom;
        it.cls = cls[1:0];
        case ($urandom_range(0, 3))
            0: it.size = 16'($urandom_range(0, 2));
            1: it.size = 16'hFFFF;
            default: it.size = 16'($urandom);
        endcase
        return it;
    endfunction

    function automatic t_pkt_item deq_item();
        t_pkt_item it;
        it = '0;
        it.kind = KIND_DEQ;
        it.ident = $urandom;
        it.cls = 2'($urandom);
        it.size = 16'($urandom);
        return it;
    endfunction

    task automatic rand_phase(int n);
        for (int k = 0; k < n; k++) begin
            if ($urandom_range(0, 1) == 0) pending_items.push_back(rand_enq($urandom_range(0, 3)));
            else pending_items.push_back(deq_item());
        end
        wait_drained();
    endtask

    initial begin
        t_pkt_item it;
        mismatches = 0;
        cycle_count = 0;
        long_hold_req = 0;
        driving_done = 0;
        in_ch.valid = 0;
        in_ch.kind = 0;
        in_ch.packet_ident = 0;
        in_ch.traffic_class = 0;
        in_ch.size_in_bytes = 0;
        cfg_ch.valid = 0;
        cfg_ch.index = 0;
        cfg_ch.data = 0;
        out_ch.ready = 0;
        for (int c = 0; c < NCLS; c++) begin
            sh_head[c] = 0;
            sh_count[c] = 0;
            sh_last[c] = 0;
            sh_weight[c] = 1;
        end
        sh_vclock = 0;
        i_rst_n = 0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // directed: empty dequeue, zero size, max size, fill class 0 past full
        pending_items.push_back(deq_item());
        it = rand_enq(1); it.size = 0; pending_items.push_back(it);
        it = rand_enq(2); it.size = 16'hFFFF; it.ident = 32'hFFFF_FFFF;
        pending_items.push_back(it);
        it = rand_enq(3); it.size = 16'hFFFF; it.ident = 0; pending_items.push_back(it);
        for (int k = 0; k < DEPTH + 2; k++) pending_items.push_back(rand_enq(0));
        pending_items.push_back(deq_item());
        pending_items.push_back(deq_item());
        wait_drained();

        // saturation with weight 1 is slow; zero weight acts as 1
        write_weight(2'd0, 16'd0);
        write_weight(2'd1, 16'hFFFF);
        write_weight(2'd2, 16'd1);
        write_weight(2'd3, 16'h8000);
        rand_phase(300);

        // back-pressure: long receiver stall while sender keeps going
        @(posedge i_clk);
        long_hold_req <= 1;
        @(posedge i_clk);
        long_hold_req <= 0;
        rand_phase(200);

        for (int p = 0; p < 6; p++) begin
            for (int c = 0; c < NCLS; c++) write_weight(c[1:0], 16'($urandom_range(1, 65535)));
            rand_phase(230);
        end
        // long chain of max-size packets at weight 1: largest costs
        for (int c = 0; c < NCLS; c++) write_weight(c[1:0], 16'd1);
        for (int k = 0; k < 40; k++) begin
            it = rand_enq($urandom_range(0, 3)); it.size = 16'hFFFF;
            pending_items.push_back(it);
            pending_items.push_back(deq_item());
        end
        wait_drained();

        if (mismatches == 0 && expected_results.size() == 0) begin
            $display("tb_top: clean");
        end else begin
            $display("tb_top: errors");
        end
        $finish;
    end
endmodule
